@@ hw/rtl/chm_pkg.sv @@
// Package for the chained hash map: sizes, status codes and controller states.
// No dependencies.
`timescale 1ns / 1ps
package chm_pkg;
  localparam int unsigned BucketBits  = 10;
  localparam int unsigned PoolEntries = 1024;
  localparam int unsigned KeyWidth    = 32;

  localparam logic [3:0]  IndexBitsRst  = 4'd10;
  localparam logic [10:0] MaxEntriesRst = 11'd1024;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  localparam logic CmdPut = 1'b0;
  localparam logic CmdGet = 1'b1;

  localparam logic RegIndexBits  = 1'b0;
  localparam logic RegMaxEntries = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_DONE
  } state_e;
endpackage

@@ hw/rtl/chained_hash_map.sv @@
// Chained hash map top level: APB config, bucket head memory, entry pool memory.
// Depends on chm_pkg.
`timescale 1ns / 1ps
// One put or get per start; busy stays high until the result strobe, so a new
// start is taken only once the last item is through. An item takes a head read,
// one pool read per chain entry visited, and a result step. After reset a clearing
// pass writes the bucket heads empty while busy is high.
// Results appear for one cycle with done_o and cannot be stalled.
module chained_hash_map #(
  parameter int unsigned BUCKET_BITS  = chm_pkg::BucketBits,
  parameter int unsigned POOL_ENTRIES = chm_pkg::PoolEntries,
  parameter int unsigned KEY_WIDTH    = chm_pkg::KeyWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        found_existing_o,
  output logic [31:0] result_value_o
);
  localparam int unsigned NB = 1 << BUCKET_BITS;
  localparam int unsigned PW = $clog2(POOL_ENTRIES);
  localparam int unsigned CW = PW + 1;
  localparam int unsigned KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int unsigned IBW = $clog2(BUCKET_BITS + 1);

  logic [3:0]  index_bits_q;
  logic [10:0] max_entries_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q  <= chm_pkg::IndexBitsRst;
      max_entries_q <= chm_pkg::MaxEntriesRst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == chm_pkg::RegIndexBits) index_bits_q <= pwdata[3:0];
      else max_entries_q <= pwdata[10:0];
    end
  end
  assign prdata = (paddr[2] == chm_pkg::RegMaxEntries) ? {21'd0, max_entries_q}
                                                       : {28'd0, index_bits_q};

  // memories: head = {valid, index}; pool = {link valid, link, key, value}
  localparam int unsigned EW = 1 + PW + KW + 32;
  logic [PW:0]   head_mem [NB];
  logic [EW-1:0] pool_mem [POOL_ENTRIES];
  logic [PW:0]   head_rd_q;
  logic [EW-1:0] pool_rd_q;

  chm_pkg::state_e state_q, state_d;
  logic [BUCKET_BITS-1:0] bkt_q, bkt_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] p_q, p_d;
  logic [CW-1:0] steps_q, steps_d;
  logic cmd_q, cmd_d;
  logic [KW-1:0] key_q, key_d;
  logic [31:0] val_q, val_d;
  logic [1:0] st_q, st_d;
  logic fnd_q, fnd_d;
  logic [31:0] rv_q, rv_d;

  logic head_we, pool_we;
  logic [BUCKET_BITS-1:0] head_wa;
  logic [PW:0] head_wd;
  logic [PW-1:0] pool_wa, pool_ra;
  logic [EW-1:0] pool_wd;

  logic [IBW-1:0] ib;
  logic [BUCKET_BITS-1:0] bmask, bkt_in;
  logic [CW-1:0] limit;
  logic accept;

  always_comb begin
    ib = (32'(index_bits_q) > BUCKET_BITS) ? IBW'(BUCKET_BITS) : IBW'(index_bits_q);
    bmask = BUCKET_BITS'(({{BUCKET_BITS{1'b0}}, 1'b1} << ib) - 1'b1);
    bkt_in = key_i[BUCKET_BITS-1:0] & bmask;
    limit = (32'(max_entries_q) > POOL_ENTRIES) ? CW'(POOL_ENTRIES)
                                                : CW'(max_entries_q);
  end

  assign accept = start && !busy;
  assign busy = (state_q != chm_pkg::S_IDLE);

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[bkt_d];
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
    pool_rd_q <= pool_mem[pool_ra];
  end

  // chain walk step values
  logic [PW-1:0] cur_p;
  logic [KW-1:0] e_key;
  logic hit, in_range;
  always_comb begin
    e_key = pool_rd_q[32 +: KW];
    hit = (e_key == key_q);
    in_range = ({1'b0, p_q} < count_q) && (steps_q < CW'(POOL_ENTRIES));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      chm_pkg::S_CLEAR: if (bkt_q == BUCKET_BITS'(NB - 1)) state_d = chm_pkg::S_IDLE;
      chm_pkg::S_IDLE:  if (accept) state_d = chm_pkg::S_HEAD;
      chm_pkg::S_HEAD:  state_d = (head_rd_q[PW] && ({1'b0, head_rd_q[PW-1:0]} < count_q))
                                  ? chm_pkg::S_WALK : chm_pkg::S_DONE;
      chm_pkg::S_WALK:  if (!in_range || hit || !pool_rd_q[EW-1]) state_d = chm_pkg::S_DONE;
      chm_pkg::S_DONE:  state_d = chm_pkg::S_IDLE;
      default:          state_d = chm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    bkt_d = bkt_q; count_d = count_q; p_d = p_q; steps_d = steps_q;
    cmd_d = cmd_q; key_d = key_q; val_d = val_q;
    st_d = st_q; fnd_d = fnd_q; rv_d = rv_q;
    head_we = 1'b0; head_wa = bkt_q; head_wd = '0;
    pool_we = 1'b0; pool_wa = count_q[PW-1:0]; pool_wd = '0;
    pool_ra = p_q;
    cur_p = p_q;
    case (state_q)
      chm_pkg::S_CLEAR: begin
        head_we = 1'b1;
        bkt_d = bkt_q + 1'b1;
      end
      chm_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i; key_d = key_i[KW-1:0]; val_d = value_i; bkt_d = bkt_in;
        end
      end
      chm_pkg::S_HEAD: begin
        p_d = head_rd_q[PW-1:0];
        pool_ra = head_rd_q[PW-1:0];
        steps_d = '0;
        st_d = (cmd_q == chm_pkg::CmdGet) ? chm_pkg::StNotFound : chm_pkg::StOk;
        fnd_d = 1'b0; rv_d = '0;
      end
      chm_pkg::S_WALK: begin
        if (in_range && hit) begin
          fnd_d = 1'b1; st_d = chm_pkg::StOk;
          if (cmd_q == chm_pkg::CmdGet) rv_d = pool_rd_q[31:0];
          else begin
            pool_we = 1'b1; pool_wa = p_q;
            pool_wd = {pool_rd_q[EW-1:32], val_q};
          end
        end else begin
          cur_p = pool_rd_q[32+KW +: PW];
          p_d = cur_p; pool_ra = cur_p;
          steps_d = steps_q + 1'b1;
        end
      end
      chm_pkg::S_DONE: begin
        if (cmd_q == chm_pkg::CmdPut && !fnd_q) begin
          if (count_q >= limit) st_d = chm_pkg::StFull;
          else begin
            pool_we = 1'b1;
            pool_wd = {head_rd_q[PW], head_rd_q[PW-1:0], key_q, val_q};
            head_we = 1'b1;
            head_wd = {1'b1, count_q[PW-1:0]};
            count_d = count_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chm_pkg::S_CLEAR;
      bkt_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      bkt_q   <= bkt_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; steps_q <= steps_d; cmd_q <= cmd_d; key_q <= key_d; val_q <= val_d;
    fnd_q <= fnd_d; rv_q <= rv_d;
    st_q <= (state_q == chm_pkg::S_DONE) ? st_q : st_d;
  end

  logic done_q;
  logic [1:0] so_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= (state_q == chm_pkg::S_DONE);
  end
  always_ff @(posedge clk_i) so_q <= st_d;

  assign done_o = done_q;
  assign status_o = so_q;
  assign found_existing_o = fnd_q;
  assign result_value_o = rv_q;

  a_count_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(POOL_ENTRIES)) else $error("entry count overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chm_pkg::S_WALK) |-> busy) else $error("walk while idle");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == chm_pkg::StFull) |-> !found_existing_o)
    else $error("full with hit");
endmodule
